>>> hw/rtl/imdu_pkg.sv
// package for the integer multiply/divide unit
// holds the operation codes, controller states and the control and status structs
// no dependencies
package imdu_pkg;

  localparam int unsigned ModeWidth   = 3;
  localparam int unsigned ResultWidth = 32;
  localparam int unsigned OperandWidth = 32;

  typedef enum logic [ModeWidth-1:0] {
    MODE_MUL   = 3'd0,
    MODE_DIV_U = 3'd1,
    MODE_DIV_S = 3'd2,
    MODE_REM_U = 3'd3,
    MODE_REM_S = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/imdu_in_if.sv
// input channel of the multiply/divide unit: mode and two operands
// depends on imdu_pkg
interface imdu_in_if
  import imdu_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [ModeWidth-1:0]    mode;
  logic [OperandWidth-1:0] operand_a;
  logic [OperandWidth-1:0] operand_b;

  modport source (output valid, output mode, output operand_a, output operand_b, input ready);
  modport sink (input valid, input mode, input operand_a, input operand_b, output ready);
endinterface

>>> hw/rtl/imdu_out_if.sv
// result channel of the multiply/divide unit: one result word
// depends on imdu_pkg
interface imdu_out_if
  import imdu_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [ResultWidth-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

>>> hw/rtl/imdu_ctrl.sv
// controller of the multiply/divide unit: state machine and step counter
// depends on imdu_pkg
module imdu_ctrl
  import imdu_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam int unsigned CntWidth = $clog2(DATA_WIDTH);

  state_e              state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                last_step;

  assign last_step = (cnt_q == CntWidth'(DATA_WIDTH - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CALC;
      ST_CALC: if (last_step) state_d = ST_DONE;
      ST_DONE: if (status_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cnt_d          = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        cnt_d      = '0;
      end
      ST_CALC: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
      end
      ST_DONE: begin
        cmd_o.out_load = status_i.out_free;
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // exactly one step per operand bit before the result is formed
  a_calc_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC && last_step) |=> (state_q == ST_DONE))
    else $error("calculation did not end after the last step");

  a_load_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_CALC && cnt_q == '0))
    else $error("transfer in did not start a fresh calculation");

endmodule

>>> hw/rtl/imdu_dp.sv
// datapath of the multiply/divide unit: operand registers, an adder, a
// subtractor, sign fix-up and output register; depends on imdu_pkg
module imdu_dp
  import imdu_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o,
  input  logic [ModeWidth-1:0]    mode_i,
  input  logic [OperandWidth-1:0] operand_a_i,
  input  logic [OperandWidth-1:0] operand_b_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ResultWidth-1:0]  result_o
);

  localparam int unsigned W = DATA_WIDTH;

  logic [W-1:0]           acc_q, acc_d;
  logic [W-1:0]           x_q, x_d;
  logic [W-1:0]           y_q, y_d;
  mode_e                  mode_q;
  logic                   neg_q;
  logic                   dz_q;
  logic [ResultWidth-1:0] res_q;
  logic                   out_valid_q;

  logic [W-1:0] a_w, b_w, a_mag, b_mag;
  logic         signed_mode;
  mode_e        mode_in;
  logic [W-1:0] rsh;
  logic [W:0]   diff;
  logic         take;
  logic [W-1:0] fin;

  assign mode_in     = mode_e'(mode_i);
  assign a_w         = W'(operand_a_i);
  assign b_w         = W'(operand_b_i);
  assign a_mag       = a_w[W-1] ? (~a_w + 1'b1) : a_w;
  assign b_mag       = b_w[W-1] ? (~b_w + 1'b1) : b_w;
  assign signed_mode = (mode_in == MODE_DIV_S) || (mode_in == MODE_REM_S);

  // restoring division step
  assign rsh  = {acc_q[W-2:0], x_q[W-1]};
  assign diff = {1'b0, rsh} - {1'b0, y_q};
  assign take = acc_q[W-1] | ~diff[W];

  always_comb begin
    acc_d = acc_q;
    x_d   = x_q;
    y_d   = y_q;
    if (cmd_i.load) begin
      acc_d = '0;
      x_d   = signed_mode ? a_mag : a_w;
      y_d   = signed_mode ? b_mag : b_w;
    end else if (cmd_i.step) begin
      if (mode_q == MODE_MUL) begin
        acc_d = acc_q + (x_q[0] ? y_q : '0);
        x_d   = {1'b0, x_q[W-1:1]};
        y_d   = {y_q[W-2:0], 1'b0};
      end else begin
        acc_d = take ? diff[W-1:0] : rsh;
        x_d   = {x_q[W-2:0], take};
      end
    end
  end

  always_comb begin
    case (mode_q)
      MODE_MUL:   fin = acc_q;
      MODE_DIV_U: fin = x_q;
      MODE_REM_U: fin = acc_q;
      MODE_DIV_S: fin = neg_q ? (~x_q + 1'b1) : x_q;
      MODE_REM_S: fin = neg_q ? (~acc_q + 1'b1) : acc_q;
      default:    fin = '0;
    endcase
    if (dz_q && mode_q != MODE_MUL) fin = '0;
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    if (cmd_i.load) begin
      mode_q <= mode_in;
      neg_q  <= (mode_in == MODE_DIV_S) ? (a_w[W-1] ^ b_w[W-1]) : a_w[W-1];
      dz_q   <= (b_w == '0);
    end
    if (cmd_i.out_load) res_q <= ResultWidth'(fin);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = ~out_valid_q | out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign result_o          = res_q;

  // the output register is only overwritten once its word has left
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transfer");

  a_out_after_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("result not presented after load");

endmodule

>>> hw/rtl/integer_mul_div_unit_core.sv
// top level of the integer multiply/divide unit
// depends on imdu_pkg, imdu_in_if, imdu_out_if, imdu_ctrl and imdu_dp
//
// One item at a time: a transfer in, then DATA_WIDTH iterations of an adder
// or subtractor (shift-add multiply or restoring divide, one bit each), then
// the sign fix-up into the output register. The next transfer in is taken as
// soon as the result sits in the output register, even if the result has not
// yet been taken. Operands and result are 32-bit ports; the arithmetic runs at
// DATA_WIDTH bits, operands truncated or zero-extended. Division or modulus
// by zero and unused modes give 0.
module integer_mul_div_unit_core
  import imdu_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  imdu_in_if.sink    in_i,
  imdu_out_if.source out_o
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  imdu_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  imdu_dp #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .mode_i     (in_i.mode),
    .operand_a_i(in_i.operand_a),
    .operand_b_i(in_i.operand_b),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .result_o   (out_o.result)
  );

  assign in_i.ready = in_ready;

endmodule

>>> tb/tb_top.sv
// self-checking testbench for integer_mul_div_unit_core: directed and random operands
// across all modes, checked against an in-bench predictor, with randomised idling on both sides
// depends on imdu_pkg, imdu_in_if, imdu_out_if and the unit's rtl
module tb_top;
  import imdu_pkg::*;

  localparam logic [ModeWidth-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [ModeWidth-1:0] MODE_SPARE_LAST  = 3'd7;
  localparam int RANDOM_PER_PHASE = 225;
  localparam int STALL_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 40;

  typedef struct packed {
    logic [ModeWidth-1:0]    mode;
    logic [OperandWidth-1:0] a;
    logic [OperandWidth-1:0] b;
  } op_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  imdu_in_if  in_if ();
  imdu_out_if out_if ();

  integer_mul_div_unit_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  op_item_t                 operand_queue[$];
  logic [ResultWidth-1:0]   pending_results[$];
  op_item_t                 next_item;
  int                       send_idle_pct  = 0;
  int                       recv_stall_pct = 0;
  int                       error_cnt      = 0;
  int                       quiet_cycles   = 0;

  always #5 clk_i = ~clk_i;

  function automatic logic [ResultWidth-1:0] muldiv_value(logic [ModeWidth-1:0] mode,
                                                          logic [OperandWidth-1:0] a,
                                                          logic [OperandWidth-1:0] b);
    logic [OperandWidth-1:0] mag_a;
    logic [OperandWidth-1:0] mag_b;
    logic [OperandWidth-1:0] quo;
    logic [OperandWidth-1:0] rem;
    mag_a = a[OperandWidth-1] ? -a : a;
    mag_b = b[OperandWidth-1] ? -b : b;
    if (b != '0) begin
      quo = mag_a / mag_b;
      rem = mag_a % mag_b;
    end else begin
      quo = '0;
      rem = '0;
    end
    case (mode)
      MODE_MUL:   return a * b;
      MODE_DIV_U: return (b == '0) ? '0 : a / b;
      MODE_REM_U: return (b == '0) ? '0 : a % b;
      MODE_DIV_S: return (a[OperandWidth-1] != b[OperandWidth-1]) ? -quo : quo;
      MODE_REM_S: return a[OperandWidth-1] ? -rem : rem;
      default:    return '0;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [ResultWidth-1:0] got,
                                 logic [ResultWidth-1:0] want);
    $display("%0t: %s got %h expected %h", $time, what, got, want);
    error_cnt++;
  endtask

  task automatic add_item(logic [ModeWidth-1:0] mode, logic [OperandWidth-1:0] a,
                          logic [OperandWidth-1:0] b);
    operand_queue.push_back('{mode: mode, a: a, b: b});
  endtask

  function automatic logic [OperandWidth-1:0] pick_operand();
    logic [OperandWidth-1:0] specials[5];
    specials = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    case ($urandom_range(5))
      0:       return $urandom_range(15);
      1:       return -$urandom_range(16, 1);
      2:       return specials[$urandom_range(4)];
      3:       return 32'h1 << $urandom_range(OperandWidth - 1);
      4:       return $urandom >> $urandom_range(OperandWidth - 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (operand_queue.size() != 0 || in_if.valid || pending_results.size() != 0)
      @(negedge clk_i);
  endtask

  // driver: one transfer per handshake, new item only once the current one has gone
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.mode      <= '0;
      in_if.operand_a <= '0;
      in_if.operand_b <= '0;
    end else begin
      if (in_if.valid && in_if.ready)
        pending_results.push_back(muldiv_value(in_if.mode, in_if.operand_a, in_if.operand_b));
      if (!in_if.valid || in_if.ready) begin
        if (operand_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = operand_queue.pop_front();
          in_if.valid     <= 1'b1;
          in_if.mode      <= next_item.mode;
          in_if.operand_a <= next_item.a;
          in_if.operand_b <= next_item.b;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure and in-order comparison
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0)
          report_mismatch("unexpected result", out_if.result, '0);
        else if (out_if.result !== pending_results[0])
          report_mismatch("result", out_if.result, pending_results.pop_front());
        else
          void'(pending_results.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int send_pct[4];
    int recv_pct[4];
    logic [ModeWidth-1:0] mode;
    send_pct = '{0, 74, 0, 35};
    recv_pct = '{0, 0, 74, 35};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes, zero divisors, most negative over minus one, unused modes
    add_item(MODE_MUL, 32'hffff_ffff, 32'hffff_ffff);
    add_item(MODE_MUL, 32'h8000_0000, 32'h2);
    add_item(MODE_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    add_item(MODE_MUL, 32'h0, 32'h1234_5678);
    add_item(MODE_DIV_U, 32'hffff_ffff, 32'h1);
    add_item(MODE_DIV_U, 32'hffff_ffff, 32'hffff_ffff);
    add_item(MODE_DIV_U, 32'h7, 32'h0);
    add_item(MODE_DIV_U, 32'h0, 32'h5);
    add_item(MODE_DIV_U, 32'h8000_0000, 32'h3);
    add_item(MODE_DIV_S, 32'h8000_0000, 32'hffff_ffff);
    add_item(MODE_DIV_S, 32'hffff_fff9, 32'h2);
    add_item(MODE_DIV_S, 32'h7, 32'hffff_fffe);
    add_item(MODE_DIV_S, 32'hffff_fff9, 32'hffff_fffe);
    add_item(MODE_DIV_S, 32'h5, 32'h0);
    add_item(MODE_REM_U, 32'hffff_ffff, 32'ha);
    add_item(MODE_REM_U, 32'h9, 32'h0);
    add_item(MODE_REM_U, 32'h3, 32'hffff_ffff);
    add_item(MODE_REM_S, 32'h8000_0000, 32'hffff_ffff);
    add_item(MODE_REM_S, 32'hffff_fff9, 32'h2);
    add_item(MODE_REM_S, 32'h7, 32'hffff_fffe);
    add_item(MODE_REM_S, 32'hffff_ffff, 32'h0);
    add_item(MODE_SPARE_FIRST, 32'hffff_ffff, 32'h3);
    add_item(MODE_SPARE_FIRST + 3'd1, 32'h1234_5678, 32'h0);
    add_item(MODE_SPARE_LAST, 32'h8000_0000, 32'hffff_ffff);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(99) < 12)
          mode = ModeWidth'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
        else
          mode = ModeWidth'($urandom_range(MODE_REM_S));
        add_item(mode, pick_operand(), pick_operand());
      end
      // hold the sender back until everything in flight has come out
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_cnt == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
